// ----- rtl/sntp_response_clock_discipline_assert.svh -----
// assertion macros for the sntp response clock discipline block
`ifndef SNTP_RESPONSE_CLOCK_DISCIPLINE_ASSERT_SVH
`define SNTP_RESPONSE_CLOCK_DISCIPLINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SRCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sntp clock discipline check failed");

// next-cycle implication, checked outside reset
`define SRCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sntp clock discipline check failed");

`endif

// ----- rtl/sntp_rcd_pkg.sv -----
// shared types and codes for the sntp response clock discipline block
`timescale 1ns / 1ps
`default_nettype none

package sntp_rcd_pkg;

    localparam int TS_W      = 64;
    localparam int THR_W     = 31;
    localparam int STATUS_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SLEW_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANIC_LIMIT = 2'd1;

    localparam logic [THR_W-1:0] SLEW_LIMIT_RESET  = 31'd1;
    localparam logic [THR_W-1:0] PANIC_LIMIT_RESET = 31'd1000;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_REPLY   = 1'b1;

    localparam logic [1:0] LEAP_UNSYNCED = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_RECORDED     = 4'd0;
    localparam logic [STATUS_W-1:0] STATUS_WRONG_SOURCE = 4'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNSYNCED     = 4'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_STRATUM  = 4'd3;
    localparam logic [STATUS_W-1:0] STATUS_NONE_PENDING = 4'd4;
    localparam logic [STATUS_W-1:0] STATUS_ORIGIN_BAD   = 4'd5;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_XMIT    = 4'd6;
    localparam logic [STATUS_W-1:0] STATUS_FILTERED     = 4'd7;
    localparam logic [STATUS_W-1:0] STATUS_SLEW         = 4'd8;
    localparam logic [STATUS_W-1:0] STATUS_PANIC        = 4'd9;
    localparam logic [STATUS_W-1:0] STATUS_STEP         = 4'd10;

    typedef struct packed {
        logic            operation;
        logic [TS_W-1:0] local_time;
        logic            source_ok;
        logic [1:0]      leap_code;
        logic [7:0]      server_stratum;
        logic [TS_W-1:0] origin_stamp;
        logic [TS_W-1:0] receive_stamp;
        logic [TS_W-1:0] transmit_stamp;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TS_W-1:0]     round_delay;
        logic [TS_W-1:0]     clock_offset;
        logic                min_update;
        logic [TS_W-1:0]     min_delay_next;
    } calc_out_t;

endpackage

`default_nettype wire

// ----- rtl/sntp_rcd_calc.sv -----
// reply checks, delay and offset arithmetic, delay filter and clock decision
`timescale 1ns / 1ps
`default_nettype none

module sntp_rcd_calc (
    input  wire sntp_rcd_pkg::item_t                   item,
    input  wire logic [sntp_rcd_pkg::TS_W-1:0]         outstanding,
    input  wire logic [sntp_rcd_pkg::TS_W-1:0]         min_delay,
    input  wire logic [sntp_rcd_pkg::THR_W-1:0]        slew_limit,
    input  wire logic [sntp_rcd_pkg::THR_W-1:0]        panic_limit,
    output sntp_rcd_pkg::calc_out_t                    result
);

    logic [sntp_rcd_pkg::TS_W-1:0] rstamp;
    logic [sntp_rcd_pkg::TS_W-1:0] delay;
    logic [sntp_rcd_pkg::TS_W-1:0] offset_raw;
    logic [sntp_rcd_pkg::TS_W-1:0] offset;
    logic [sntp_rcd_pkg::TS_W-1:0] diff;
    logic [sntp_rcd_pkg::TS_W-1:0] quot;
    logic [sntp_rcd_pkg::TS_W-1:0] filt;
    logic [sntp_rcd_pkg::TS_W-1:0] mag;
    logic [31:0]                   whole;
    logic                          diff_neg;
    logic                          filtered;

    assign rstamp     = (item.receive_stamp == '0) ? item.transmit_stamp : item.receive_stamp;
    assign delay      = (item.local_time + rstamp) - (item.origin_stamp + item.transmit_stamp);
    assign offset_raw = (rstamp + item.transmit_stamp) - (item.origin_stamp + item.local_time);
    assign offset     = {offset_raw[63], offset_raw[63:1]};

    // running filter: min + floor((delay - min) / 16) without overflow
    assign diff     = delay - min_delay;
    assign diff_neg = $signed(delay) < $signed(min_delay);
    assign quot     = {{4{diff_neg}}, diff[63:4]};
    assign filt     = min_delay + quot;

    assign filtered = ($signed(rstamp) >= $signed(item.origin_stamp))
                   && ($signed(item.local_time) >= $signed(item.transmit_stamp))
                   && ($signed(delay) >= $signed(filt));

    assign mag   = offset[63] ? (64'd0 - offset) : offset;
    assign whole = mag[63:32];

    always_comb
    begin
        result.status         = sntp_rcd_pkg::STATUS_RECORDED;
        result.round_delay    = '0;
        result.clock_offset   = '0;
        result.min_update     = 1'b0;
        result.min_delay_next = delay;
        if (item.operation == sntp_rcd_pkg::OP_REQUEST)
        begin
            result.status = sntp_rcd_pkg::STATUS_RECORDED;
        end
        else if (!item.source_ok)
        begin
            result.status = sntp_rcd_pkg::STATUS_WRONG_SOURCE;
        end
        else if (item.leap_code == sntp_rcd_pkg::LEAP_UNSYNCED)
        begin
            result.status = sntp_rcd_pkg::STATUS_UNSYNCED;
        end
        else if (item.server_stratum == 8'd0 || item.server_stratum[7:4] != 4'd0)
        begin
            result.status = sntp_rcd_pkg::STATUS_BAD_STRATUM;
        end
        else if (outstanding == '0)
        begin
            result.status = sntp_rcd_pkg::STATUS_NONE_PENDING;
        end
        else if (item.origin_stamp != outstanding)
        begin
            result.status = sntp_rcd_pkg::STATUS_ORIGIN_BAD;
        end
        else if (item.transmit_stamp == '0)
        begin
            result.status = sntp_rcd_pkg::STATUS_ZERO_XMIT;
        end
        else
        begin
            result.round_delay  = delay;
            result.clock_offset = offset;
            result.min_update   = 1'b1;
            if (filtered)
            begin
                result.status         = sntp_rcd_pkg::STATUS_FILTERED;
                result.min_delay_next = filt;
            end
            else if (whole < {1'b0, slew_limit})
            begin
                result.status = sntp_rcd_pkg::STATUS_SLEW;
            end
            else if (panic_limit != '0 && whole >= {1'b0, panic_limit})
            begin
                result.status = sntp_rcd_pkg::STATUS_PANIC;
            end
            else
            begin
                result.status = sntp_rcd_pkg::STATUS_STEP;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sntp_response_clock_discipline.sv -----
// top level: input stage, state, result register and checks
//
// channel   dir   handshake             payload
// in        in    in_valid / in_ready   operation .. transmit_stamp
// out       out   out_valid / out_ready status, round_delay, clock_offset
// cfg       in    cfg_write_en          cfg_index, cfg_data
//
// words pass input then result register, one word per cycle while out_ready holds
// the input register feeds the decision logic, which updates the
// outstanding stamp and the delay filter as the word moves to the result register
// reset loads default thresholds and zeroes the state, no words held
// a stalled result blocks the input stage only once that stage also holds a word
`timescale 1ns / 1ps
`default_nettype none

`include "sntp_response_clock_discipline_assert.svh"

module sntp_response_clock_discipline (
    input  wire                                          clk,
    input  wire                                          rst_n,
    input  wire                                          in_valid,
    output logic                                         in_ready,
    input  wire                                          operation,
    input  wire  [sntp_rcd_pkg::TS_W-1:0]                local_time,
    input  wire                                          source_ok,
    input  wire  [1:0]                                   leap_code,
    input  wire  [7:0]                                   server_stratum,
    input  wire  [sntp_rcd_pkg::TS_W-1:0]                origin_stamp,
    input  wire  [sntp_rcd_pkg::TS_W-1:0]                receive_stamp,
    input  wire  [sntp_rcd_pkg::TS_W-1:0]                transmit_stamp,
    output logic                                         out_valid,
    input  wire                                          out_ready,
    output logic [sntp_rcd_pkg::STATUS_W-1:0]            status,
    output logic signed [sntp_rcd_pkg::TS_W-1:0]         round_delay,
    output logic signed [sntp_rcd_pkg::TS_W-1:0]         clock_offset,
    input  wire                                          cfg_write_en,
    input  wire  [sntp_rcd_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire  [sntp_rcd_pkg::THR_W-1:0]               cfg_data
);

    logic                              stage_valid_reg;
    logic                              stage_valid_next;
    sntp_rcd_pkg::item_t               stage_item_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [sntp_rcd_pkg::STATUS_W-1:0] out_status_reg;
    logic [sntp_rcd_pkg::TS_W-1:0]     out_delay_reg;
    logic [sntp_rcd_pkg::TS_W-1:0]     out_offset_reg;
    logic [sntp_rcd_pkg::TS_W-1:0]     outstanding_reg;
    logic [sntp_rcd_pkg::TS_W-1:0]     outstanding_next;
    logic [sntp_rcd_pkg::TS_W-1:0]     min_delay_reg;
    logic [sntp_rcd_pkg::TS_W-1:0]     min_delay_next;
    logic [sntp_rcd_pkg::THR_W-1:0]    step_thr_reg;
    logic [sntp_rcd_pkg::THR_W-1:0]    panic_thr_reg;
    logic                              advance;
    logic                              retire;
    sntp_rcd_pkg::item_t               in_item;
    sntp_rcd_pkg::calc_out_t           calc;

    assign in_item.operation      = operation;
    assign in_item.local_time     = local_time;
    assign in_item.source_ok      = source_ok;
    assign in_item.leap_code      = leap_code;
    assign in_item.server_stratum = server_stratum;
    assign in_item.origin_stamp   = origin_stamp;
    assign in_item.receive_stamp  = receive_stamp;
    assign in_item.transmit_stamp = transmit_stamp;

    assign advance  = !out_valid_reg || out_ready;
    assign retire   = advance && stage_valid_reg;
    assign in_ready = !stage_valid_reg || advance;

    sntp_rcd_calc u_calc (
        .item        (stage_item_reg),
        .outstanding (outstanding_reg),
        .min_delay   (min_delay_reg),
        .slew_limit  (step_thr_reg),
        .panic_limit (panic_thr_reg),
        .result      (calc)
    );

    always_comb
    begin
        stage_valid_next = in_ready ? in_valid : stage_valid_reg;
        out_valid_next   = advance ? stage_valid_reg : out_valid_reg;
        outstanding_next = outstanding_reg;
        min_delay_next   = min_delay_reg;
        if (retire)
        begin
            if (stage_item_reg.operation == sntp_rcd_pkg::OP_REQUEST)
            begin
                outstanding_next = stage_item_reg.local_time;
            end
            else
            begin
                outstanding_next = '0;
            end
            if (calc.min_update)
            begin
                min_delay_next = calc.min_delay_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            outstanding_reg <= '0;
            min_delay_reg   <= '0;
            step_thr_reg    <= sntp_rcd_pkg::SLEW_LIMIT_RESET;
            panic_thr_reg   <= sntp_rcd_pkg::PANIC_LIMIT_RESET;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            outstanding_reg <= outstanding_next;
            min_delay_reg   <= min_delay_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    sntp_rcd_pkg::REG_SLEW_LIMIT:  step_thr_reg  <= cfg_data;
                    sntp_rcd_pkg::REG_PANIC_LIMIT: panic_thr_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_item_reg <= in_item;
        end
        if (retire)
        begin
            out_status_reg <= calc.status;
            out_delay_reg  <= calc.round_delay;
            out_offset_reg <= calc.clock_offset;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign round_delay  = $signed(out_delay_reg);
    assign clock_offset = $signed(out_offset_reg);

    // rejected or recorded words carry no arithmetic
    `SRCD_ASSERT_NOW(a_reject_zero, out_valid && status < sntp_rcd_pkg::STATUS_FILTERED,
        round_delay == '0 && clock_offset == '0)
    // no status code beyond step
    `SRCD_ASSERT_NOW(a_status_range, out_valid, status <= sntp_rcd_pkg::STATUS_STEP)
    // a held stage word survives a stall
    `SRCD_ASSERT_NEXT(a_stage_hold, stage_valid_reg && !advance,
        stage_valid_reg && $stable(stage_item_reg))
    // any reply leaves nothing outstanding
    `SRCD_ASSERT_NEXT(a_reply_clears, retire
        && stage_item_reg.operation == sntp_rcd_pkg::OP_REPLY, outstanding_reg == '0)

endmodule

`default_nettype wire
